@@ design/mh64_pkg.sv @@
// shared constants, command and status types for the murmur64a hash unit
package mh64_pkg;

    localparam int WORD_W = 64;
    localparam int SEED_W = 32;
    localparam int TAIL_W = 3;
    localparam int HALF_W = WORD_W / 2;

    localparam logic [WORD_W-1:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
    localparam int                MIX_SHIFT = 47;

    // multiplier operand sources
    localparam logic [2:0] SRC_LEN  = 3'd0;
    localparam logic [2:0] SRC_WORD = 3'd1;
    localparam logic [2:0] SRC_ACC  = 3'd2;
    localparam logic [2:0] SRC_HASH = 3'd3;
    localparam logic [2:0] SRC_TAIL = 3'd4;
    localparam logic [2:0] SRC_AVAL = 3'd5;

    typedef struct packed {
        logic       capture;
        logic       mul_issue;
        logic [2:0] mul_src;
        logic       start_msg;
        logic       acc_load;
        logic       hash_mix;
        logic       hash_load;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic tail_nz;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

@@ design/mh64_stream_if.sv @@
// valid/ready channel interfaces for message words and finished hashes
interface mh64_in_if;
    import mh64_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic [WORD_W-1:0] message_length;
    logic              first_word;
    logic              last_word;

    modport source (output valid, data_word, message_length, first_word, last_word,
                    input ready);
    modport sink   (input valid, data_word, message_length, first_word, last_word,
                    output ready);
endinterface

interface mh64_out_if;
    import mh64_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

@@ design/murmur64a_stream_hash_unit.sv @@
// MurmurHash64A over a stream of little-endian 64-bit words. The first word of a
// message carries its byte length, which seeds the running hash; the word marked
// last ends the message and yields one 64-bit hash on the output channel. One
// word is taken at a time, and the block is not ready for another until it is through
// with the one it took: a middle full word is mixed and folded into the running hash,
// a first word adds the length product, a last word adds the final avalanche, a partial
// tail on the last word goes in unmixed in place of a full word's mix, and words of an empty
// message are not mixed. These steps are set by the single shared two-stage constant
// multiplier, which every product of the hash passes through in turn. A finished
// hash waits in the output register while the next message is taken; a further
// hash holds the block in its avalanche until the waiting one is accepted, which
// stalls the input. The seed port writes the 32-bit seed and must only be used
// while no word is in flight.
module murmur64a_stream_hash_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        hash_seed_we,
    input  logic [mh64_pkg::SEED_W-1:0] hash_seed_wdata,
    mh64_in_if.sink                     in_ch,
    mh64_out_if.source                  out_ch
);
    import mh64_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mh64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_first  (in_ch.first_word),
        .in_last   (in_ch.last_word),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mh64_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed_we        (hash_seed_we),
        .seed_wdata     (hash_seed_wdata),
        .data_word      (in_ch.data_word),
        .message_length (in_ch.message_length),
        .cmd            (cmd),
        .status         (status),
        .hash_value     (out_ch.hash_value)
    );

endmodule

@@ design/mh64_mul.sv @@
// two-stage 64-bit multiply by the mix constant, low 64 bits of the product
module mh64_mul (
    input  logic                        clk,
    input  logic                        issue,
    input  logic [mh64_pkg::WORD_W-1:0] operand,
    output logic [mh64_pkg::WORD_W-1:0] product
);
    import mh64_pkg::*;

    localparam logic [HALF_W-1:0] C_LO = MIX_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] C_HI = MIX_MULT[WORD_W-1:HALF_W];

    logic [WORD_W-1:0] p_ll;
    logic [HALF_W-1:0] p_hl;
    logic [HALF_W-1:0] p_lh;
    logic [WORD_W-1:0] pp_ll_reg;
    logic [HALF_W-1:0] pp_hl_reg;
    logic [HALF_W-1:0] pp_lh_reg;
    logic [HALF_W-1:0] cross_sum;

    assign p_ll = WORD_W'(operand[HALF_W-1:0]) * WORD_W'(C_LO);
    // cross terms only feed the upper half, so their low 32 bits suffice
    assign p_hl = operand[WORD_W-1:HALF_W] * C_LO;
    assign p_lh = operand[HALF_W-1:0] * C_HI;

    // partial products held until the next issue
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pp_ll_reg <= p_ll;
            pp_hl_reg <= p_hl;
            pp_lh_reg <= p_lh;
        end
    end

    assign cross_sum = pp_hl_reg + pp_lh_reg;
    assign product   = pp_ll_reg + {cross_sum, {HALF_W{1'b0}}};

endmodule

@@ design/mh64_dp.sv @@
// datapath: seed, running hash, word buffers, multiplier and output register
module mh64_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_we,
    input  logic [mh64_pkg::SEED_W-1:0] seed_wdata,
    input  logic [mh64_pkg::WORD_W-1:0] data_word,
    input  logic [mh64_pkg::WORD_W-1:0] message_length,
    input  mh64_pkg::dp_cmd_t           cmd,
    output mh64_pkg::dp_status_t        status,
    output logic [mh64_pkg::WORD_W-1:0] hash_value
);
    import mh64_pkg::*;

    logic [SEED_W-1:0] seed_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] len_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] hash_next;
    logic [TAIL_W-1:0] tail_reg;
    logic              empty_reg;
    logic [WORD_W-1:0] out_reg;
    logic [WORD_W-1:0] tail_mask;
    logic [WORD_W-1:0] mul_operand;
    logic [WORD_W-1:0] product;

    // keep bytes below the tail count
    always_comb
    begin
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            tail_mask[i*8 +: 8] = (i < int'(tail_reg)) ? 8'hff : 8'h00;
        end
    end

    always_comb
    begin
        unique case (cmd.mul_src)
            SRC_LEN:  mul_operand = len_reg;
            SRC_WORD: mul_operand = word_reg;
            SRC_ACC:  mul_operand = acc_reg;
            SRC_HASH: mul_operand = hash_reg;
            SRC_TAIL: mul_operand = hash_reg ^ (word_reg & tail_mask);
            SRC_AVAL: mul_operand = xorshift(hash_reg);
            default:  mul_operand = '0;
        endcase
    end

    mh64_mul u_mul (
        .clk     (clk),
        .issue   (cmd.mul_issue),
        .operand (mul_operand),
        .product (product)
    );

    always_comb
    begin
        priority if (cmd.start_msg)
            hash_next = {{(WORD_W-SEED_W){1'b0}}, seed_reg} ^ product;
        else if (cmd.hash_mix)
            hash_next = hash_reg ^ product;
        else if (cmd.hash_load)
            hash_next = product;
        else
            hash_next = hash_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            hash_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b0;
        end
        else
        begin
            if (seed_we)
                seed_reg <= seed_wdata;
            hash_reg <= hash_next;
            if (cmd.start_msg)
            begin
                tail_reg  <= len_reg[TAIL_W-1:0];
                empty_reg <= (len_reg == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg <= data_word;
            len_reg  <= message_length;
        end
        if (cmd.acc_load)
            acc_reg <= xorshift(product);
        if (cmd.out_load)
            out_reg <= xorshift(product);
    end

    assign status.empty   = empty_reg;
    assign status.tail_nz = (tail_reg != '0);
    assign hash_value     = out_reg;

endmodule

@@ design/mh64_ctrl.sv @@
// controller: sequences the multiplier passes for each word and the output handshake
module mh64_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_first,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mh64_pkg::dp_status_t status,
    output mh64_pkg::dp_cmd_t    cmd
);
    import mh64_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LEN_M1 = 4'd1;
    localparam logic [3:0] ST_LEN_M2 = 4'd2;
    localparam logic [3:0] ST_DISP   = 4'd3;
    localparam logic [3:0] ST_T_M1   = 4'd4;
    localparam logic [3:0] ST_T_M2   = 4'd5;
    localparam logic [3:0] ST_W1_M1  = 4'd6;
    localparam logic [3:0] ST_W1_M2  = 4'd7;
    localparam logic [3:0] ST_W2_M1  = 4'd8;
    localparam logic [3:0] ST_W2_M2  = 4'd9;
    localparam logic [3:0] ST_H_M1   = 4'd10;
    localparam logic [3:0] ST_H_M2   = 4'd11;
    localparam logic [3:0] ST_AV_M1  = 4'd12;
    localparam logic [3:0] ST_AV_M2  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       last_reg;
    logic       last_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.mul_src = SRC_LEN;
        in_ready   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    state_next  = in_first ? ST_LEN_M1 : ST_DISP;
                end
            end
            ST_LEN_M1:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_src   = SRC_LEN;
                state_next    = ST_LEN_M2;
            end
            ST_LEN_M2:
            begin
                cmd.start_msg = 1'b1;
                state_next    = ST_DISP;
            end
            ST_DISP:
            begin
                priority if (status.empty)
                    state_next = last_reg ? ST_AV_M1 : ST_IDLE;
                else if (last_reg && status.tail_nz)
                    state_next = ST_T_M1;
                else
                    state_next = ST_W1_M1;
            end
            ST_T_M1:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_src   = SRC_TAIL;
                state_next    = ST_T_M2;
            end
            ST_T_M2:
            begin
                cmd.hash_load = 1'b1;
                state_next    = ST_AV_M1;
            end
            ST_W1_M1:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_src   = SRC_WORD;
                state_next    = ST_W1_M2;
            end
            ST_W1_M2:
            begin
                cmd.acc_load = 1'b1;
                state_next   = ST_W2_M1;
            end
            ST_W2_M1:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_src   = SRC_ACC;
                state_next    = ST_W2_M2;
            end
            ST_W2_M2:
            begin
                cmd.hash_mix = 1'b1;
                state_next   = ST_H_M1;
            end
            ST_H_M1:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_src   = SRC_HASH;
                state_next    = ST_H_M2;
            end
            ST_H_M2:
            begin
                cmd.hash_load = 1'b1;
                state_next    = last_reg ? ST_AV_M1 : ST_IDLE;
            end
            ST_AV_M1:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_src   = SRC_AVAL;
                state_next    = ST_AV_M2;
            end
            ST_AV_M2:
            begin
                // wait here until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/mh64_checker.sv @@
// port-level checks for the hash unit, bound to the top level
module mh64_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_last,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mh64_pkg::WORD_W-1:0] hash_value
);
    import mh64_pkg::*;

    // one word at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after a word was accepted");

    // a hash never appears the cycle after a word is taken
    a_no_instant_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("hash appeared too early after an accepted word");

    // a new hash only follows a word marked last
    a_hash_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_last) |=> ##1 !$rose(out_valid))
        else $error("hash appeared after a word not marked last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hash_value)))
        else $error("stalled hash changed or was dropped");

endmodule

bind murmur64a_stream_hash_unit mh64_checker u_mh64_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_last    (in_ch.last_word),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .hash_value (out_ch.hash_value)
);

@@ verif/murmur64a_hash_check.sv @@
// watches the word and hash channels, predicts each murmur64a hash and compares
`timescale 1ns / 1ps

module murmur64a_hash_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        hash_seed_we,
    input  logic [mh64_pkg::SEED_W-1:0] hash_seed_wdata,
    mh64_in_if                          in_ch,
    mh64_out_if                         out_ch,
    output int                          fail_count,
    output int                          pending_hashes,
    output int                          hashes_seen
);
    import mh64_pkg::*;

    logic [SEED_W-1:0] seed_q;
    logic [WORD_W-1:0] run_hash;
    logic [TAIL_W-1:0] tail_cnt;
    logic              empty_msg;
    logic [WORD_W-1:0] expected_hashes[$];

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] mixed;
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            seed_q         = '0;
            run_hash       = '0;
            tail_cnt       = '0;
            empty_msg      = 1'b0;
            fail_count     = 0;
            pending_hashes = 0;
            hashes_seen    = 0;
            expected_hashes.delete();
        end
        else
        begin
            // retire the older expectation before a new last word can add one
            if (out_ch.valid && out_ch.ready)
            begin
                hashes_seen++;
                if (expected_hashes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected hash %h, expected none", $time,
                             out_ch.hash_value);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (out_ch.hash_value !== want)
                    begin
                        fail_count++;
                        $display("%0t: hash_value mismatch, expected %h, actual %h", $time,
                                 want, out_ch.hash_value);
                    end
                end
            end

            if (hash_seed_we)
                seed_q = hash_seed_wdata;

            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.first_word)
                begin
                    run_hash  = {{(WORD_W-SEED_W){1'b0}}, seed_q}
                                ^ (in_ch.message_length * MIX_MULT);
                    tail_cnt  = in_ch.message_length[TAIL_W-1:0];
                    empty_msg = (in_ch.message_length == '0);
                end
                if (!empty_msg)
                begin
                    // a tail only counts on the last word, and goes in unmixed
                    if (in_ch.last_word && tail_cnt != '0)
                    begin
                        run_hash = run_hash
                                   ^ (in_ch.data_word & ((64'd1 << (8 * tail_cnt)) - 64'd1));
                    end
                    else
                    begin
                        mixed    = in_ch.data_word * MIX_MULT;
                        mixed    = mixed ^ (mixed >> MIX_SHIFT);
                        mixed    = mixed * MIX_MULT;
                        run_hash = run_hash ^ mixed;
                    end
                    run_hash = run_hash * MIX_MULT;
                end
                if (in_ch.last_word)
                begin
                    mixed = run_hash ^ (run_hash >> MIX_SHIFT);
                    mixed = mixed * MIX_MULT;
                    mixed = mixed ^ (mixed >> MIX_SHIFT);
                    expected_hashes.push_back(mixed);
                end
            end

            pending_hashes = expected_hashes.size();
        end
    end

endmodule

@@ verif/murmur64a_stream_hash_unit_tb.sv @@
// stimulus, clocking and verdict for the murmur64a stream hash unit
`timescale 1ns / 1ps

module murmur64a_stream_hash_unit_tb;
    import mh64_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT      = 31;
    localparam int PHASE_WORDS   = 100;
    localparam int HOLD_CYCLES   = 400;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              hash_seed_we;
    logic [SEED_W-1:0] hash_seed_wdata;

    int fail_count;
    int pending_hashes;
    int hashes_seen;
    int words_sent  = 0;
    int cycle_count = 0;

    mh64_in_if  in_ch ();
    mh64_out_if out_ch ();

    murmur64a_stream_hash_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .in_ch           (in_ch),
        .out_ch          (out_ch)
    );

    murmur64a_hash_check i_hash_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .fail_count      (fail_count),
        .pending_hashes  (pending_hashes),
        .hashes_seen     (hashes_seen)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one word, idling at random first outside words 200 to 299, and return once it is taken
    task automatic send_word(input logic [WORD_W-1:0] data, input logic [WORD_W-1:0] len,
                             input logic first, input logic last);
        while (!(words_sent >= 200 && words_sent < 300) && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_word      <= data;
        in_ch.message_length <= len;
        in_ch.first_word     <= first;
        in_ch.last_word      <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // drain all hashes, then give a word still in flight time to finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_hashes != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // hash receiver: random stalls, one long hold-off, one stretch always ready
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && hashes_seen >= 30)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (hashes_seen >= 60 && hashes_seen < 100)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        logic [SEED_W-1:0] seeds[4];
        logic [WORD_W-1:0] len;
        int                nwords;
        int                phase_end;

        rst_n                = 1'b0;
        hash_seed_we         = 1'b0;
        hash_seed_wdata      = '0;
        in_ch.valid          = 1'b0;
        in_ch.data_word      = '0;
        in_ch.message_length = '0;
        in_ch.first_word     = 1'b0;
        in_ch.last_word      = 1'b0;
        seeds[0] = 32'hffff_ffff;
        seeds[1] = 32'h0000_0000;
        seeds[2] = $urandom;
        seeds[3] = $urandom;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words under the reset seed
        // continuation straight after reset, then a last word with no tail
        send_word(64'hffff_ffff_ffff_ffff, rand64(), 1'b0, 1'b0);
        send_word(64'h0, rand64(), 1'b0, 1'b1);
        // empty message, single word and spread over three words
        send_word(64'hffff_ffff_ffff_ffff, 64'd0, 1'b1, 1'b1);
        send_word(rand64(), 64'd0, 1'b1, 1'b0);
        send_word(rand64(), rand64(), 1'b0, 1'b0);
        send_word(rand64(), rand64(), 1'b0, 1'b1);
        // first and last together with a short tail
        send_word(64'hffff_ffff_ffff_ffff, 64'd5, 1'b1, 1'b1);
        // largest length, tail of seven
        send_word(64'h0, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
        send_word(64'hffff_ffff_ffff_ffff, 64'h0, 1'b0, 1'b1);
        // tail set but middle words still mix in full
        send_word(rand64(), 64'd3, 1'b1, 1'b0);
        send_word(rand64(), rand64(), 1'b0, 1'b0);
        send_word(rand64(), rand64(), 1'b0, 1'b1);
        // whole words only
        send_word(rand64(), 64'd16, 1'b1, 1'b0);
        send_word(rand64(), 64'd0, 1'b0, 1'b1);
        // more words than the length says
        send_word(rand64(), 64'd8, 1'b1, 1'b0);
        send_word(rand64(), rand64(), 1'b0, 1'b0);
        send_word(rand64(), rand64(), 1'b0, 1'b1);
        // continuation of a finished message, then a single byte
        send_word(rand64(), rand64(), 1'b0, 1'b1);
        send_word(rand64(), 64'd1, 1'b1, 1'b1);

        foreach (seeds[p])
        begin
            settle();
            hash_seed_we    <= 1'b1;
            hash_seed_wdata <= seeds[p];
            @(negedge clk);
            hash_seed_we    <= 1'b0;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(99) < 80)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        len    = rand64();
                        nwords = $urandom_range(1, 4);
                    end
                    else
                    begin
                        len    = 64'($urandom_range(0, 40));
                        nwords = (len == 0) ? int'($urandom_range(1, 2))
                                            : int'((len + 7) / 8);
                    end
                    for (int i = 0; i < nwords; i++)
                        send_word(rand64(), (i == 0) ? len : rand64(), i == 0, i == nwords - 1);
                end
                else
                begin
                    send_word(rand64(), rand64(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end

        settle();
        $display("run covered %0d message words and %0d hashes under %0d seeds",
                 words_sent, hashes_seen, 5);
        $display("including empty, tail, miscounted and long hold-off cases");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
